[src/upwind_flux_term_van_leer_unit_defines.svh]
// Assertion macros shared by the checker of the upwinded flux unit.
// Depends on nothing; every macro expects clk and rst_n in scope.
`ifndef UPWIND_FLUX_TERM_VAN_LEER_UNIT_DEFINES_SVH
`define UPWIND_FLUX_TERM_VAN_LEER_UNIT_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define UFVL_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define UFVL_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[src/ufvl_pkg.sv]
// Shared constants for the upwinded flux unit.
// Depends on nothing.
package ufvl_pkg;

    // Default word format: Q16.16.
    localparam int WORD_BITS_DEF = 32;
    localparam int FRAC_BITS_DEF = 16;

    // Quotient bits resolved by each divider stage.
    localparam int DIV_STEPS = 4;

endpackage

[src/upwind_flux_term_van_leer_unit.sv]
// Upwinded flux term with van Leer harmonic limiting, Q16.16 by default. The unit takes one
// word per cycle while the output is not stalled, and returns one result word for each,
// in order. The restoring divider resolves four quotient bits per pipeline stage. A stalled
// output word holds the whole pipeline, so in_ready is low exactly while out_valid waits
// for out_ready. Builds on ufvl_pkg, ufvl_front, ufvl_div and ufvl_back.
module upwind_flux_term_van_leer_unit #(
    parameter int WORD_BITS = ufvl_pkg::WORD_BITS_DEF,
    parameter int FRAC_BITS = ufvl_pkg::FRAC_BITS_DEF
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    output logic                        in_ready,
    input  logic                        func,
    input  logic signed [WORD_BITS-1:0] steer,
    input  logic signed [WORD_BITS-1:0] centre_operand,
    input  logic signed [WORD_BITS-1:0] minus_operand,
    input  logic signed [WORD_BITS-1:0] plus_operand,
    input  logic signed [WORD_BITS-1:0] prior_flux,
    output logic                        out_valid,
    input  logic                        out_ready,
    output logic signed [WORD_BITS-1:0] updated_flux,
    output logic                        saturated
);
    import ufvl_pkg::*;

    localparam int SIDE_BITS = 3 * WORD_BITS + 4;

    logic                        adv;
    logic                        f_vld;
    logic [2*WORD_BITS-1:0]      f_num;
    logic [WORD_BITS:0]          f_den;
    logic                        f_func, f_hneg, f_hv;
    logic signed [WORD_BITS-1:0] f_steer, f_prior;
    logic signed [WORD_BITS:0]   f_sum;
    logic [SIDE_BITS-1:0]        side_in, side_out;
    logic                        d_vld;
    logic [WORD_BITS:0]          d_quot;
    logic                        d_func, d_hneg, d_hv;
    logic signed [WORD_BITS-1:0] d_steer, d_prior;
    logic signed [WORD_BITS:0]   d_sum;

    // The pipeline moves whenever the output word is empty or being taken.
    assign adv      = !out_valid || out_ready;
    assign in_ready = adv;

    ufvl_front #(
        .WORD_BITS (WORD_BITS)
    ) u_front (
        .clk            (clk),
        .rst_n          (rst_n),
        .adv            (adv),
        .in_valid       (in_valid),
        .func           (func),
        .steer          (steer),
        .centre_operand (centre_operand),
        .minus_operand  (minus_operand),
        .plus_operand   (plus_operand),
        .prior_flux     (prior_flux),
        .out_valid      (f_vld),
        .num            (f_num),
        .den            (f_den),
        .func_q         (f_func),
        .steer_q        (f_steer),
        .sum_q          (f_sum),
        .hneg_q         (f_hneg),
        .hvalid_q       (f_hv),
        .prior_q        (f_prior)
    );

    // Fields that ride alongside the divider.
    assign side_in = {f_func, f_steer, f_sum, f_hneg, f_hv, f_prior};
    assign {d_func, d_steer, d_sum, d_hneg, d_hv, d_prior} = side_out;

    ufvl_div #(
        .WORD_BITS (WORD_BITS),
        .SIDE_BITS (SIDE_BITS)
    ) u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .adv       (adv),
        .in_valid  (f_vld),
        .num       (f_num),
        .den       (f_den),
        .side_in   (side_in),
        .out_valid (d_vld),
        .quot      (d_quot),
        .side_out  (side_out)
    );

    ufvl_back #(
        .WORD_BITS (WORD_BITS),
        .FRAC_BITS (FRAC_BITS)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .adv       (adv),
        .in_valid  (d_vld),
        .quot      (d_quot),
        .func      (d_func),
        .steer     (d_steer),
        .sum       (d_sum),
        .hneg      (d_hneg),
        .hvalid    (d_hv),
        .prior     (d_prior),
        .out_valid (out_valid),
        .flux      (updated_flux),
        .sat       (saturated)
    );

endmodule

[src/ufvl_front.sv]
// Operand decode and magnitude product for the upwinded flux unit.
// Depends on ufvl_pkg; two register stages.
module ufvl_front #(
    parameter int WORD_BITS = ufvl_pkg::WORD_BITS_DEF
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        adv,
    input  logic                        in_valid,
    input  logic                        func,
    input  logic signed [WORD_BITS-1:0] steer,
    input  logic signed [WORD_BITS-1:0] centre_operand,
    input  logic signed [WORD_BITS-1:0] minus_operand,
    input  logic signed [WORD_BITS-1:0] plus_operand,
    input  logic signed [WORD_BITS-1:0] prior_flux,
    output logic                        out_valid,
    output logic [2*WORD_BITS-1:0]      num,
    output logic [WORD_BITS:0]          den,
    output logic                        func_q,
    output logic signed [WORD_BITS-1:0] steer_q,
    output logic signed [WORD_BITS:0]   sum_q,
    output logic                        hneg_q,
    output logic                        hvalid_q,
    output logic signed [WORD_BITS-1:0] prior_q
);
    import ufvl_pkg::*;

    logic signed [WORD_BITS-1:0] nsel;
    logic [WORD_BITS-1:0]        cmag_next, nmag_next;
    logic signed [WORD_BITS:0]   sum_next;
    logic [WORD_BITS:0]          den_next;
    logic                        hv_next;

    logic                        a_vld_reg, b_vld_reg;
    logic [WORD_BITS-1:0]        cmag_reg, nmag_reg;
    logic signed [WORD_BITS:0]   a_sum_reg, b_sum_reg;
    logic [WORD_BITS:0]          a_den_reg, b_den_reg;
    logic                        a_func_reg, b_func_reg;
    logic signed [WORD_BITS-1:0] a_steer_reg, b_steer_reg;
    logic signed [WORD_BITS-1:0] a_prior_reg, b_prior_reg;
    logic                        a_hneg_reg, b_hneg_reg;
    logic                        a_hv_reg, b_hv_reg;
    logic [2*WORD_BITS-1:0]      prod_c;
    logic [2*WORD_BITS-1:0]      num_reg;

    // Pick the upwind neighbour and take magnitudes, sum and divisor.
    always_comb
    begin
        nsel      = steer[WORD_BITS-1] ? plus_operand : minus_operand;
        cmag_next = centre_operand[WORD_BITS-1] ? (~centre_operand + 1'b1) : centre_operand;
        nmag_next = nsel[WORD_BITS-1] ? (~nsel + 1'b1) : nsel;
        sum_next  = {centre_operand[WORD_BITS-1], centre_operand} + {nsel[WORD_BITS-1], nsel};
        den_next  = {1'b0, cmag_next} + {1'b0, nmag_next};
        hv_next   = (centre_operand != '0) && (nsel != '0)
                    && (centre_operand[WORD_BITS-1] == nsel[WORD_BITS-1]);
    end

    // The product of the magnitudes, doubled, is the harmonic numerator.
    assign prod_c = cmag_reg * nmag_reg;

    // Valid bits of both stages.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_vld_reg <= 1'b0;
            b_vld_reg <= 1'b0;
        end
        else if (adv)
        begin
            a_vld_reg <= in_valid;
            b_vld_reg <= a_vld_reg;
        end
    end

    // Payload of both stages.
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            cmag_reg    <= cmag_next;
            nmag_reg    <= nmag_next;
            a_sum_reg   <= sum_next;
            a_den_reg   <= den_next;
            a_func_reg  <= func;
            a_steer_reg <= steer;
            a_prior_reg <= prior_flux;
            a_hneg_reg  <= centre_operand[WORD_BITS-1];
            a_hv_reg    <= hv_next;

            num_reg     <= {prod_c[2*WORD_BITS-2:0], 1'b0};
            b_sum_reg   <= a_sum_reg;
            b_den_reg   <= a_den_reg;
            b_func_reg  <= a_func_reg;
            b_steer_reg <= a_steer_reg;
            b_prior_reg <= a_prior_reg;
            b_hneg_reg  <= a_hneg_reg;
            b_hv_reg    <= a_hv_reg;
        end
    end

    assign out_valid = b_vld_reg;
    assign num       = num_reg;
    assign den       = b_den_reg;
    assign func_q    = b_func_reg;
    assign steer_q   = b_steer_reg;
    assign sum_q     = b_sum_reg;
    assign hneg_q    = b_hneg_reg;
    assign hvalid_q  = b_hv_reg;
    assign prior_q   = b_prior_reg;

endmodule

[src/ufvl_div.sv]
// Pipelined restoring divider for the harmonic mean, with a sideband word.
// Depends on ufvl_pkg for the number of quotient bits per stage.
module ufvl_div #(
    parameter int WORD_BITS = ufvl_pkg::WORD_BITS_DEF,
    parameter int SIDE_BITS = 3 * ufvl_pkg::WORD_BITS_DEF + 4
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   adv,
    input  logic                   in_valid,
    input  logic [2*WORD_BITS-1:0] num,
    input  logic [WORD_BITS:0]     den,
    input  logic [SIDE_BITS-1:0]   side_in,
    output logic                   out_valid,
    output logic [WORD_BITS:0]     quot,
    output logic [SIDE_BITS-1:0]   side_out
);
    import ufvl_pkg::*;

    // The quotient never exceeds 2^WORD_BITS, so WORD_BITS+1 bits are resolved.
    localparam int QBITS  = WORD_BITS + 1;
    localparam int NSTAGE = (QBITS + DIV_STEPS - 1) / DIV_STEPS;

    logic [NSTAGE-1:0]    vld_reg;
    logic [WORD_BITS:0]   rem_reg  [NSTAGE];
    logic [WORD_BITS:0]   low_reg  [NSTAGE];
    logic [WORD_BITS:0]   quo_reg  [NSTAGE];
    logic [WORD_BITS:0]   den_reg  [NSTAGE];
    logic [SIDE_BITS-1:0] side_reg [NSTAGE];

    for (genvar k = 0; k < NSTAGE; k++)
    begin : g_stage
        logic                 vld_in;
        logic [WORD_BITS:0]   rem_in, low_in, quo_in, den_in;
        logic [SIDE_BITS-1:0] side_s;
        logic [WORD_BITS:0]   rem_next, low_next, quo_next;

        if (k == 0)
        begin : g_first
            // The top bits of the numerator already lie below the divisor.
            assign vld_in = in_valid;
            assign rem_in = {2'b00, num[2*WORD_BITS-1:WORD_BITS+1]};
            assign low_in = num[WORD_BITS:0];
            assign quo_in = '0;
            assign den_in = den;
            assign side_s = side_in;
        end
        else
        begin : g_rest
            assign vld_in = vld_reg[k-1];
            assign rem_in = rem_reg[k-1];
            assign low_in = low_reg[k-1];
            assign quo_in = quo_reg[k-1];
            assign den_in = den_reg[k-1];
            assign side_s = side_reg[k-1];
        end

        // Up to DIV_STEPS compare-and-subtract steps, one quotient bit each.
        always_comb
        begin
            logic [WORD_BITS+1:0] trial;
            logic [WORD_BITS:0]   rem_v, low_v, quo_v;
            rem_v = rem_in;
            low_v = low_in;
            quo_v = quo_in;
            trial = '0;
            for (int i = 0; i < DIV_STEPS; i++)
            begin
                if (k * DIV_STEPS + i < QBITS)
                begin
                    trial = {rem_v, low_v[WORD_BITS]};
                    low_v = {low_v[WORD_BITS-1:0], 1'b0};
                    if (trial >= {1'b0, den_in})
                    begin
                        trial = trial - {1'b0, den_in};
                        quo_v = {quo_v[WORD_BITS-1:0], 1'b1};
                    end
                    else
                    begin
                        quo_v = {quo_v[WORD_BITS-1:0], 1'b0};
                    end
                    rem_v = trial[WORD_BITS:0];
                end
            end
            rem_next = rem_v;
            low_next = low_v;
            quo_next = quo_v;
        end

        // Stage valid bit.
        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                vld_reg[k] <= 1'b0;
            end
            else if (adv)
            begin
                vld_reg[k] <= vld_in;
            end
        end

        // Stage payload.
        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                rem_reg[k]  <= rem_next;
                low_reg[k]  <= low_next;
                quo_reg[k]  <= quo_next;
                den_reg[k]  <= den_in;
                side_reg[k] <= side_s;
            end
        end
    end

    assign out_valid = vld_reg[NSTAGE-1];
    assign quot      = quo_reg[NSTAGE-1];
    assign side_out  = side_reg[NSTAGE-1];

endmodule

[src/ufvl_back.sv]
// Term product, scaling with term clipping, and saturating flux add.
// Depends on ufvl_pkg; three register stages, the last being the output word.
module ufvl_back #(
    parameter int WORD_BITS = ufvl_pkg::WORD_BITS_DEF,
    parameter int FRAC_BITS = ufvl_pkg::FRAC_BITS_DEF
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        adv,
    input  logic                        in_valid,
    input  logic [WORD_BITS:0]          quot,
    input  logic                        func,
    input  logic signed [WORD_BITS-1:0] steer,
    input  logic signed [WORD_BITS:0]   sum,
    input  logic                        hneg,
    input  logic                        hvalid,
    input  logic signed [WORD_BITS-1:0] prior,
    output logic                        out_valid,
    output logic signed [WORD_BITS-1:0] flux,
    output logic                        sat
);
    import ufvl_pkg::*;

    localparam logic [WORD_BITS-1:0] WMAX = {1'b0, {(WORD_BITS-1){1'b1}}};
    localparam logic [WORD_BITS-1:0] WMIN = {1'b1, {(WORD_BITS-1){1'b0}}};

    logic signed [WORD_BITS+1:0]   qext, op_c;
    logic signed [2*WORD_BITS+1:0] prod_next, prod_reg, sh_c;
    logic [WORD_BITS+2:0]          hi_c;
    logic [WORD_BITS-1:0]          term_next, term_reg;
    logic                          tsat_next, tsat_reg;
    logic signed [WORD_BITS:0]     add_c;
    logic [WORD_BITS-1:0]          flux_next, flux_reg;
    logic                          sat_next, sat_reg;
    logic                          c_vld_reg, d_vld_reg, e_vld_reg;
    logic                          c_func_reg;
    logic signed [WORD_BITS-1:0]   c_prior_reg, d_prior_reg;

    // Multiplier operand: the neighbour sum, or the signed harmonic mean, zero when it is not valid.
    always_comb
    begin
        qext = $signed({1'b0, quot});
        if (func)
        begin
            if (hvalid)
            begin
                op_c = hneg ? -qext : qext;
            end
            else
            begin
                op_c = '0;
            end
        end
        else
        begin
            op_c = {sum[WORD_BITS], sum};
        end
        prod_next = steer * op_c;
    end

    // Floor scaling, then clip the term to the word range.
    always_comb
    begin
        sh_c = c_func_reg ? (prod_reg >>> FRAC_BITS) : (prod_reg >>> (FRAC_BITS + 1));
        hi_c = sh_c[2*WORD_BITS+1:WORD_BITS-1];
        if ((&hi_c) || !(|hi_c))
        begin
            term_next = sh_c[WORD_BITS-1:0];
            tsat_next = 1'b0;
        end
        else
        begin
            term_next = sh_c[2*WORD_BITS+1] ? WMIN : WMAX;
            tsat_next = 1'b1;
        end
    end

    // Add the term to the prior flux and saturate.
    always_comb
    begin
        add_c = {d_prior_reg[WORD_BITS-1], d_prior_reg} + {term_reg[WORD_BITS-1], term_reg};
        if (add_c[WORD_BITS] != add_c[WORD_BITS-1])
        begin
            flux_next = add_c[WORD_BITS] ? WMIN : WMAX;
            sat_next  = 1'b1;
        end
        else
        begin
            flux_next = add_c[WORD_BITS-1:0];
            sat_next  = tsat_reg;
        end
    end

    // Valid bits of the three stages.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            c_vld_reg <= 1'b0;
            d_vld_reg <= 1'b0;
            e_vld_reg <= 1'b0;
        end
        else if (adv)
        begin
            c_vld_reg <= in_valid;
            d_vld_reg <= c_vld_reg;
            e_vld_reg <= d_vld_reg;
        end
    end

    // Payload of the three stages.
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            prod_reg    <= prod_next;
            c_func_reg  <= func;
            c_prior_reg <= prior;
            term_reg    <= term_next;
            tsat_reg    <= tsat_next;
            d_prior_reg <= c_prior_reg;
            flux_reg    <= flux_next;
            sat_reg     <= sat_next;
        end
    end

    assign out_valid = e_vld_reg;
    assign flux      = flux_reg;
    assign sat       = sat_reg;

endmodule

[src/ufvl_checker.sv]
// Port-level checks for the upwinded flux unit, bound to its top level.
// Depends on the assertion macros in upwind_flux_term_van_leer_unit_defines.svh.
`include "upwind_flux_term_van_leer_unit_defines.svh"

module ufvl_checker #(
    parameter int WORD_BITS = ufvl_pkg::WORD_BITS_DEF
) (
    input logic                        clk,
    input logic                        rst_n,
    input logic                        in_valid,
    input logic                        in_ready,
    input logic                        out_valid,
    input logic                        out_ready,
    input logic signed [WORD_BITS-1:0] updated_flux,
    input logic                        saturated
);
    // Input is taken exactly when the output word is free or leaving.
    `UFVL_ASSERT_SAME(a_ready_follows_output, 1'b1, in_ready == (!out_valid || out_ready), "in_ready does not track the output stall")

    // A stalled result word holds its valid and payload.
    `UFVL_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(updated_flux) && $stable(saturated), "stalled result word changed")

    // Nothing can reach the output in the first cycle after reset.
    `UFVL_ASSERT_SAME(a_empty_after_reset, $past(!rst_n), !out_valid, "result word present straight after reset")

endmodule

bind upwind_flux_term_van_leer_unit ufvl_checker #(
    .WORD_BITS (WORD_BITS)
) u_ufvl_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .updated_flux (updated_flux),
    .saturated    (saturated)
);
